### rtl/sorted_deadline_timer_queue_top_defines.svh
// Assertion macros used by the timer queue top level.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdtq_pkg.sv
// Shared types and constants of the sorted deadline timer queue.
package sdtq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_FIRE    = 16;  // most timers fired by one tick
  localparam int FIRE_CNT_W  = $clog2(MAX_FIRE);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CREATE = 1'b1;

  localparam logic [1:0] KIND_CREATED     = 2'd0;
  localparam logic [1:0] KIND_NO_CALLBACK = 2'd1;
  localparam logic [1:0] KIND_FULL        = 2'd2;
  localparam logic [1:0] KIND_FIRED       = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] timeout;
    logic [7:0]  callback_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_id;
    logic [31:0] deadline;
    logic        last;
  } out_word_t;

  // One queue slot.
  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [7:0]  callback;
  } cell_t;

  // Command broadcast to every slot.
  typedef struct packed {
    logic        insert;
    logic        pop;
    logic [31:0] deadline;
    logic [7:0]  callback;
  } cmd_t;

endpackage

### rtl/sdtq_cell.sv
// One slot of the sorted timer chain: compare, shift in, shift out.
module sdtq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  sdtq_pkg::cmd_t  cmd,
  input  sdtq_pkg::cell_t left,     // slot nearer the head
  input  logic            left_gt,  // left slot sorts after the new entry
  input  sdtq_pkg::cell_t right,    // slot nearer the tail
  output sdtq_pkg::cell_t cur,
  output logic            gt
);

  logic        valid_r, valid_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [7:0]  callback_r, callback_nxt;

  assign cur.valid    = valid_r;
  assign cur.deadline = deadline_r;
  assign cur.callback = callback_r;

  // Empty slots sort after anything; strict compare keeps arrival order.
  assign gt = !valid_r || (deadline_r > cmd.deadline);

  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    callback_nxt = callback_r;
    if (cmd.insert && gt) begin
      if (left_gt) begin
        valid_nxt    = left.valid;
        deadline_nxt = left.deadline;
        callback_nxt = left.callback;
      end else begin
        valid_nxt    = 1'b1;
        deadline_nxt = cmd.deadline;
        callback_nxt = cmd.callback;
      end
    end else if (cmd.pop) begin
      valid_nxt    = right.valid;
      deadline_nxt = right.deadline;
      callback_nxt = right.callback;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    callback_r <= callback_nxt;
  end

endmodule

### rtl/sorted_deadline_timer_queue_top.sv
// Sorted deadline timer queue: time counter, control and the chain of timer slots.
//
// Holds a 32-bit tick counter and up to DEPTH timers in a chain of slots kept
// sorted by absolute deadline, head in slot 0. A create word adds now+timeout
// (mod 2^32) with its callback id; the new deadline is broadcast to all slots,
// each compares it in parallel and the chain opens a gap directly, so a
// create is answered in the next cycle with one word (created, rejected for a
// zero callback id, or rejected full). Equal deadlines keep arrival order.
// A tick word advances time by one; then the head slot is checked once per
// cycle and every due timer (deadline <= new time, plain unsigned compare)
// is popped and reported, one word per cycle while the output is not stalled,
// at most 16 per tick, the last one flagged; the single output register sets
// the pace and a stalled output holds the chain. A new input word is taken
// only when the block is idle and the output register is free or being
// emptied. There is no clearing pass: slot valid bits clear at reset.
`include "sorted_deadline_timer_queue_top_defines.svh"

module sorted_deadline_timer_queue_top #(
  parameter int DEPTH = sdtq_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdtq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sdtq_pkg::out_word_t out_word
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIRE = 2'b10
  } state_t;

  state_t                            state_r, state_nxt;
  logic [31:0]                       now_r, now_nxt;
  logic [sdtq_pkg::FIRE_CNT_W-1:0]   fire_cnt_r, fire_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  sdtq_pkg::out_word_t               out_word_r, out_word_nxt;

  sdtq_pkg::cell_t                   cells [DEPTH];
  logic [DEPTH-1:0]                  gts;
  logic [DEPTH-1:0]                  cell_valid;
  sdtq_pkg::cmd_t                    cmd;

  logic        out_free;
  logic        in_acc;
  logic [31:0] new_deadline;
  logic        full;
  logic        head_due;
  logic        next_due;
  logic        fire_last;

  // Output slot is usable when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign new_deadline = now_r + in_word.timeout;
  assign full         = cells[DEPTH-1].valid;

  // Head and its successor against the current time.
  assign head_due  = cells[0].valid && (cells[0].deadline <= now_r);
  assign next_due  = cells[1].valid && (cells[1].deadline <= now_r);
  assign fire_last = !next_due ||
                     (fire_cnt_r == sdtq_pkg::FIRE_CNT_W'(sdtq_pkg::MAX_FIRE - 1));

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    fire_cnt_nxt  = fire_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    cmd.insert    = 1'b0;
    cmd.pop       = 1'b0;
    cmd.deadline  = new_deadline;
    cmd.callback  = in_word.callback_id;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.op == sdtq_pkg::OP_CREATE) begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.deadline = new_deadline;
            out_word_nxt.last     = 1'b1;
            out_word_nxt.fired_id = in_word.callback_id;
            if (in_word.callback_id == 8'd0) begin
              out_word_nxt.kind = sdtq_pkg::KIND_NO_CALLBACK;
            end else if (full) begin
              out_word_nxt.kind = sdtq_pkg::KIND_FULL;
            end else begin
              out_word_nxt.kind = sdtq_pkg::KIND_CREATED;
              cmd.insert        = 1'b1;
            end
          end else begin
            now_nxt      = now_r + 32'd1;
            fire_cnt_nxt = '0;
            state_nxt    = ST_FIRE;
          end
        end
      end
      ST_FIRE: begin
        if (!head_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.kind     = sdtq_pkg::KIND_FIRED;
          out_word_nxt.fired_id = cells[0].callback;
          out_word_nxt.deadline = cells[0].deadline;
          out_word_nxt.last     = fire_last;
          cmd.pop               = 1'b1;
          fire_cnt_nxt          = fire_cnt_r + 1'b1;
          if (fire_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // Slot chain: head at index 0, tail slot shifts in an empty slot on pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdtq_pkg::cell_t left_c, right_c;
    logic            left_gt_c;

    if (i == 0) begin : g_head
      assign left_c    = '0;
      assign left_gt_c = 1'b0;
    end else begin : g_mid
      assign left_c    = cells[i-1];
      assign left_gt_c = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_body
      assign right_c = cells[i+1];
    end

    sdtq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left    (left_c),
      .left_gt (left_gt_c),
      .right   (right_c),
      .cur     (cells[i]),
      .gt      (gts[i])
    );

    assign cell_valid[i] = cells[i].valid;
  end

  // Occupied slots always form an unbroken run from the head.
  `SDTQ_ASSERT_NOW(a_valid_prefix, clk, rst_n, 1'b1,
    (cell_valid & (cell_valid + DEPTH'(1))) == '0, "timer slots not contiguous")
  // Head never sorts after its successor.
  `SDTQ_ASSERT_NOW(a_head_sorted, clk, rst_n, cells[1].valid,
    cells[0].deadline <= cells[1].deadline, "timer chain out of order")
  // A reported firing was due at the current time.
  `SDTQ_ASSERT_NOW(a_fire_due, clk, rst_n,
    out_valid && (out_word.kind == sdtq_pkg::KIND_FIRED),
    out_word.deadline <= now_r, "fired timer not yet due")
  // A successful create adds exactly one slot.
  `SDTQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.insert,
    $countones(cell_valid) == $past($countones(cell_valid)) + 1, "insert lost a slot")

endmodule
